/* rtl/core/cst_pkg.sv */
// Shared types and character codes for the call syntax command tokenizer.
// No dependencies; imported by cst_step and call_syntax_command_tokenizer_top.
package cst_pkg;

  typedef enum logic [2:0] {
    PH_NAME  = 3'd0,
    PH_ARGS  = 3'd1,
    PH_QUOTE = 3'd2,
    PH_ERROR = 3'd3,
    PH_END   = 3'd4
  } phase_t;

  localparam logic [7:0] CH_OPEN  = 8'h28; // (
  localparam logic [7:0] CH_CLOSE = 8'h29; // )
  localparam logic [7:0] CH_COMMA = 8'h2C; // ,
  localparam logic [7:0] CH_QUOTE = 8'h22; // "
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_LF    = 8'h0A;

  localparam int unsigned OUT_BITS   = 27;
  localparam int unsigned OUT_TDATA_W = 32;

  typedef struct packed {
    logic [2:0] parser_phase;
    logic [3:0] arg_total;
    logic       command_failed;
    logic       command_done;
    logic [7:0] store_byte;
    logic [4:0] char_offset;
    logic [2:0] arg_slot;
    logic       store_target;
    logic       store_valid;
  } result_t;

endpackage

/* rtl/core/call_syntax_command_tokenizer_top.sv */
// Top level of the call syntax command tokenizer: input register, step logic, result register.
// Depends on cst_pkg and cst_step.
//
// Tokenizes commands of the form name(arg,arg,"quoted text"), one character per beat, and
// returns exactly one result beat for every character beat. A character is captured in the
// input register, the parser state and the result are worked out in one pass of the step
// logic, and the result lands in the output register. One character is taken every cycle
// as long as the result side keeps up, the parser state register being the only loop. No
// reset sweep is needed; the block is ready as soon as reset is released.
module call_syntax_command_tokenizer_top #(
  parameter int unsigned MAX_ARGS      = 8,
  parameter int unsigned MAX_TOKEN_LEN = 32
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_tvalid,
  output logic                              in_tready,
  input  logic [7:0]                        in_tdata,  // [7:0] char_in
  output logic                              out_tvalid,
  input  logic                              out_tready,
  // [0] store_valid, [1] store_target, [4:2] arg_slot, [9:5] char_offset,
  // [17:10] store_byte, [18] command_done, [19] command_failed, [23:20] arg_total,
  // [26:24] parser_phase, [31:27] zero
  output logic [cst_pkg::OUT_TDATA_W-1:0]   out_tdata
);
  import cst_pkg::*;

  localparam int unsigned OFF_W = $clog2(MAX_TOKEN_LEN + 1);
  localparam int unsigned CNT_W = $clog2(MAX_ARGS + 1);

  logic             in_vld_r;
  logic [7:0]       in_char_r;
  logic             out_vld_r;
  result_t          out_res_r;
  phase_t           phase_r, phase_nxt;
  logic [OFF_W-1:0] offset_r, offset_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             first_ne_r, first_ne_nxt;
  result_t          res;
  logic             adv;

  assign adv       = in_vld_r && (!out_vld_r || out_tready);
  assign in_tready = !in_vld_r || adv;

  cst_step #(
    .OFF_W        (OFF_W),
    .CNT_W        (CNT_W),
    .MAX_ARGS     (MAX_ARGS),
    .MAX_TOKEN_LEN(MAX_TOKEN_LEN)
  ) u_step (
    .char_in           (in_char_r),
    .phase             (phase_r),
    .offset            (offset_r),
    .arg_cnt           (cnt_r),
    .first_nonempty    (first_ne_r),
    .phase_nxt         (phase_nxt),
    .offset_nxt        (offset_nxt),
    .arg_cnt_nxt       (cnt_nxt),
    .first_nonempty_nxt(first_ne_nxt),
    .res               (res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r   <= 1'b0;
      out_vld_r  <= 1'b0;
      phase_r    <= PH_NAME;
      offset_r   <= '0;
      cnt_r      <= '0;
      first_ne_r <= 1'b0;
    end else begin
      if (in_tready) begin
        in_vld_r <= in_tvalid;
      end
      if (adv) begin
        out_vld_r  <= 1'b1;
        phase_r    <= phase_nxt;
        offset_r   <= offset_nxt;
        cnt_r      <= cnt_nxt;
        first_ne_r <= first_ne_nxt;
      end else if (out_tready) begin
        out_vld_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) begin
      in_char_r <= in_tdata;
    end
    if (adv) begin
      out_res_r <= res;
    end
  end

  assign out_tvalid = out_vld_r;
  assign out_tdata  = {{(OUT_TDATA_W - OUT_BITS){1'b0}}, out_res_r};

  // done and failed are exclusive
  a_done_fail_excl: assert property (@(posedge clk) disable iff (!rst_n)
    out_vld_r |-> !(out_res_r.command_done && out_res_r.command_failed))
    else $error("done and failed reported together");

  // a closing beat always leaves the parser in the ended phase
  a_close_ends: assert property (@(posedge clk) disable iff (!rst_n)
    (out_vld_r && (out_res_r.command_done || out_res_r.command_failed))
      |-> out_res_r.parser_phase == PH_END)
    else $error("command closed without ending phase");

  // failure carries a zero count and a name terminator at offset 0
  a_fail_fields: assert property (@(posedge clk) disable iff (!rst_n)
    (out_vld_r && out_res_r.command_failed) |-> (out_res_r.arg_total == 4'd0 &&
      out_res_r.store_valid && !out_res_r.store_target && out_res_r.store_byte == 8'd0))
    else $error("bad failure result");

  // state only moves with an accepted step
  a_state_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !adv |=> $stable(phase_r) && $stable(offset_r) && $stable(cnt_r))
    else $error("parser state changed without a step");

  // offset never exceeds token limit
  a_off_bound: assert property (@(posedge clk) disable iff (!rst_n)
    offset_r <= OFF_W'(MAX_TOKEN_LEN))
    else $error("write offset beyond token limit");

endmodule

/* rtl/core/cst_step.sv */
// Per-byte tokenizer decision: next parser state and the result for one character.
// Depends on cst_pkg.
module cst_step #(
  parameter int unsigned OFF_W         = 6,
  parameter int unsigned CNT_W         = 4,
  parameter int unsigned MAX_ARGS      = 8,
  parameter int unsigned MAX_TOKEN_LEN = 32
) (
  input  logic [7:0]         char_in,
  input  cst_pkg::phase_t    phase,
  input  logic [OFF_W-1:0]   offset,
  input  logic [CNT_W-1:0]   arg_cnt,
  input  logic               first_nonempty,
  output cst_pkg::phase_t    phase_nxt,
  output logic [OFF_W-1:0]   offset_nxt,
  output logic [CNT_W-1:0]   arg_cnt_nxt,
  output logic               first_nonempty_nxt,
  output cst_pkg::result_t   res
);
  import cst_pkg::*;

  phase_t           cur;
  logic             st_en;
  logic             st_tgt;
  logic [7:0]       st_byte;
  logic [OFF_W-1:0] off;
  logic [CNT_W-1:0] cnt;
  logic             fa;
  logic             is_ws;

  assign is_ws = (char_in == CH_SPACE) || (char_in == CH_TAB);

  always_comb begin
    cur       = phase;
    off       = offset;
    cnt       = arg_cnt;
    fa        = first_nonempty;
    phase_nxt = phase;
    st_en     = 1'b0;
    st_tgt    = 1'b0;
    st_byte   = 8'd0;
    res       = '0;

    // overlong token: only checked while storing
    if (phase <= PH_QUOTE && offset >= OFF_W'(MAX_TOKEN_LEN)) begin
      off = '0;
      cur = PH_ERROR;
    end
    phase_nxt = cur;

    // what gets stored
    case (cur)
      PH_NAME: begin
        st_en   = 1'b1;
        st_byte = (char_in == CH_OPEN) ? 8'd0 : char_in;
      end
      PH_ARGS: begin
        st_tgt = 1'b1;
        if (char_in == CH_COMMA || char_in == CH_CLOSE) begin
          st_en = 1'b1;
        end else if (char_in != CH_QUOTE && !is_ws) begin
          st_en   = 1'b1;
          st_byte = char_in;
        end
      end
      PH_QUOTE: begin
        st_tgt  = 1'b1;
        st_en   = (char_in != CH_QUOTE);
        st_byte = char_in;
      end
      PH_ERROR: begin
        st_en = 1'b0;
      end
      default: begin
        if (!is_ws && char_in != CH_CR && char_in != CH_LF) begin
          st_en = 1'b1;
          off   = '0;
          st_byte = char_in;
        end
      end
    endcase

    if (st_en) begin
      res.store_valid  = 1'b1;
      res.store_target = st_tgt;
      res.arg_slot     = st_tgt ? 3'(cnt) : 3'd0;
      res.char_offset  = 5'(off);
      res.store_byte   = st_byte;
      if (st_tgt && cnt == '0 && off == '0) begin
        fa = (st_byte != 8'd0);
      end
      off = off + OFF_W'(1);
    end

    // state effects after the store
    case (cur)
      PH_NAME: begin
        if (char_in == CH_OPEN) begin
          off       = '0;
          cnt       = '0;
          fa        = 1'b0;
          phase_nxt = PH_ARGS;
        end
      end
      PH_ARGS: begin
        if (char_in == CH_COMMA) begin
          off = '0;
          cnt = cnt + CNT_W'(1);
          if (cnt >= CNT_W'(MAX_ARGS)) begin
            phase_nxt = PH_ERROR;
          end
        end else if (char_in == CH_CLOSE) begin
          cnt = cnt + CNT_W'(1);
          if (!fa) begin
            cnt = '0;
          end
          phase_nxt        = PH_END;
          res.command_done = 1'b1;
          res.arg_total    = 4'(cnt);
        end else if (char_in == CH_QUOTE) begin
          phase_nxt = PH_QUOTE;
        end
      end
      PH_QUOTE: begin
        if (char_in == CH_QUOTE) begin
          phase_nxt = PH_ARGS;
        end
      end
      PH_ERROR: begin
        if (char_in == CH_CLOSE) begin
          cnt                = '0;
          res.store_valid    = 1'b1; // terminator at name offset 0
          res.command_failed = 1'b1;
          phase_nxt          = PH_END;
        end
      end
      default: begin
        if (st_en) begin
          phase_nxt = PH_NAME;
        end
      end
    endcase

    res.parser_phase   = phase_nxt;
    offset_nxt         = off;
    arg_cnt_nxt        = cnt;
    first_nonempty_nxt = fa;
  end

endmodule

/* sim/tb_call_syntax_command_tokenizer_top.sv */
// Self-checking testbench for call_syntax_command_tokenizer_top: directed table, then random
// command streams, each result beat checked against its table entry or an in-bench tokenizer model.
// Depends on cst_pkg and the tokenizer RTL.
`timescale 1ns / 100ps

module tb_call_syntax_command_tokenizer_top;
  import cst_pkg::*;

  localparam int unsigned MAX_ARGS      = 8;
  localparam int unsigned MAX_TOKEN_LEN = 32;
  localparam int QUIET_LIMIT = 2000;
  localparam int HOLDOFF_CYCLES = 200;

  typedef struct packed {
    logic [7:0] ch;
    logic       typed;
    result_t    want;
  } probe_row_t;

  logic clk;
  logic rst_n;
  logic in_tvalid;
  logic in_tready;
  logic [7:0] in_tdata;
  logic out_tvalid;
  logic out_tready;
  logic [OUT_TDATA_W-1:0] out_tdata;

  // side info travelling with the current input beat
  logic    in_typed;
  result_t in_want;

  // tokenizer model state
  phase_t tok_phase;
  int     tok_offset;
  int     tok_args;
  logic   tok_first_nz;

  result_t    pending_results[$];
  logic [7:0] char_q[$];
  probe_row_t probe_rows[$];
  result_t    model_result;
  result_t    next_result;
  result_t    got_result;
  string      bad_fields;

  int mismatches = 0;
  int quiet_cycles = 0;
  int send_idle_pct;
  int recv_idle_pct;
  int holdoff_requests = 0;
  int holdoff_served = 0;

  call_syntax_command_tokenizer_top #(
    .MAX_ARGS      (MAX_ARGS),
    .MAX_TOKEN_LEN (MAX_TOKEN_LEN)
  ) i_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // ---------------------------------------------------------------- tokenizer model

  function automatic result_t with_store(result_t r, logic tgt, int slot, logic [7:0] b);
    r.store_valid  = 1'b1;
    r.store_target = tgt;
    r.arg_slot     = tgt ? slot[2:0] : 3'd0;
    r.char_offset  = tok_offset[4:0];
    r.store_byte   = b;
    if (tgt && slot == 0 && tok_offset == 0)
      tok_first_nz = (b != 8'h00);
    tok_offset++;
    return r;
  endfunction

  function automatic result_t tokenize_char(logic [7:0] c);
    result_t r;
    r = '0;
    if (tok_phase <= PH_QUOTE && tok_offset >= MAX_TOKEN_LEN) begin
      tok_offset = 0;
      tok_phase  = PH_ERROR;
    end
    case (tok_phase)
      PH_NAME: begin
        if (c != CH_OPEN) begin
          r = with_store(r, 1'b0, 0, c);
        end else begin
          r = with_store(r, 1'b0, 0, 8'h00);
          tok_offset   = 0;
          tok_args     = 0;
          tok_first_nz = 1'b0;
          tok_phase    = PH_ARGS;
        end
      end
      PH_ARGS: begin
        if (c == CH_COMMA) begin
          r = with_store(r, 1'b1, tok_args, 8'h00);
          tok_offset = 0;
          tok_args++;
          if (tok_args >= MAX_ARGS)
            tok_phase = PH_ERROR;
        end else if (c == CH_CLOSE) begin
          r = with_store(r, 1'b1, tok_args, 8'h00);
          tok_args++;
          // an empty first argument means no arguments at all
          if (!tok_first_nz)
            tok_args = 0;
          tok_phase      = PH_END;
          r.command_done = 1'b1;
          r.arg_total    = tok_args[3:0];
        end else if (c == CH_QUOTE) begin
          tok_phase = PH_QUOTE;
        end else if (c != CH_SPACE && c != CH_TAB) begin
          r = with_store(r, 1'b1, tok_args, c);
        end
      end
      PH_QUOTE: begin
        if (c != CH_QUOTE)
          r = with_store(r, 1'b1, tok_args, c);
        else
          tok_phase = PH_ARGS;
      end
      PH_ERROR: begin
        if (c == CH_CLOSE) begin
          tok_args         = 0;
          r.store_valid    = 1'b1;
          r.command_failed = 1'b1;
          tok_phase        = PH_END;
        end
      end
      default: begin
        if (c != CH_SPACE && c != CH_TAB && c != CH_CR && c != CH_LF) begin
          tok_phase  = PH_NAME;
          tok_offset = 0;
          r = with_store(r, 1'b0, 0, c);
        end
      end
    endcase
    r.parser_phase = tok_phase;
    return r;
  endfunction

  // ---------------------------------------------------------------- scoreboard

  function automatic string show(result_t r);
    return $sformatf("st%0d tg%0d sl%0d of%0d by%02h dn%0d fl%0d n%0d ph%0d",
                     r.store_valid, r.store_target, r.arg_slot, r.char_offset,
                     r.store_byte, r.command_done, r.command_failed, r.arg_total,
                     r.parser_phase);
  endfunction

  task automatic flag_mismatch(input string msg);
    mismatches++;
    if (mismatches <= 10)
      $display("%t: %s", $realtime, msg);
  endtask

  always @(posedge clk) begin
    if (rst_n && in_tvalid && in_tready) begin
      model_result = tokenize_char(in_tdata);
      pending_results.push_back(in_typed ? in_want : model_result);
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      got_result = out_tdata[OUT_BITS-1:0];
      if (pending_results.size() == 0) begin
        flag_mismatch({"unexpected result beat: ", show(got_result)});
      end else begin
        next_result = pending_results.pop_front();
        bad_fields = "";
        if (got_result.store_valid != next_result.store_valid)
          bad_fields = {bad_fields, " store_valid"};
        if (got_result.store_target != next_result.store_target)
          bad_fields = {bad_fields, " store_target"};
        if (got_result.arg_slot != next_result.arg_slot)
          bad_fields = {bad_fields, " arg_slot"};
        if (got_result.char_offset != next_result.char_offset)
          bad_fields = {bad_fields, " char_offset"};
        if (got_result.store_byte != next_result.store_byte)
          bad_fields = {bad_fields, " store_byte"};
        if (got_result.command_done != next_result.command_done)
          bad_fields = {bad_fields, " command_done"};
        if (got_result.command_failed != next_result.command_failed)
          bad_fields = {bad_fields, " command_failed"};
        if (got_result.arg_total != next_result.arg_total)
          bad_fields = {bad_fields, " arg_total"};
        if (got_result.parser_phase != next_result.parser_phase)
          bad_fields = {bad_fields, " parser_phase"};
        if (out_tdata[OUT_TDATA_W-1:OUT_BITS] != '0)
          bad_fields = {bad_fields, " padding"};
        if (bad_fields != "")
          flag_mismatch($sformatf("bad%s: exp %s got %s", bad_fields,
                                  show(next_result), show(got_result)));
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles + 1 >= QUIET_LIMIT) begin
      $display("watchdog: no beat for %0d cycles", QUIET_LIMIT);
      $display("SCOREBOARD MISMATCH");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // ---------------------------------------------------------------- result side

  initial begin
    out_tready = 1'b0;
    forever begin
      @(negedge clk);
      if (holdoff_served != holdoff_requests) begin
        // long hold-off so the pipe fills and back-pressures the input
        holdoff_served++;
        out_tready = 1'b0;
        repeat (HOLDOFF_CYCLES - 1) @(negedge clk);
      end else begin
        out_tready = ($urandom_range(99) >= recv_idle_pct);
      end
    end
  end

  // ---------------------------------------------------------------- stimulus

  task automatic send_char(input logic [7:0] c, input logic typed, input result_t want);
    @(negedge clk);
    while ($urandom_range(99) < send_idle_pct) begin
      in_tvalid = 1'b0;
      @(negedge clk);
    end
    in_tvalid = 1'b1;
    in_tdata  = c;
    in_typed  = typed;
    in_want   = want;
    do @(posedge clk); while (!in_tready);
  endtask

  function automatic result_t literal_result(logic v, logic tgt, logic [2:0] slot,
                                             logic [4:0] off, logic [7:0] b, logic dn,
                                             logic fl, logic [3:0] n, phase_t ph);
    result_t r;
    r.store_valid    = v;
    r.store_target   = tgt;
    r.arg_slot       = slot;
    r.char_offset    = off;
    r.store_byte     = b;
    r.command_done   = dn;
    r.command_failed = fl;
    r.arg_total      = n;
    r.parser_phase   = ph;
    return r;
  endfunction

  task automatic add_row(input logic [7:0] c, input logic typed, input result_t want);
    probe_row_t row;
    row.ch    = c;
    row.typed = typed;
    row.want  = want;
    probe_rows.push_back(row);
  endtask

  function automatic logic [7:0] ws_char();
    case ($urandom_range(3))
      0:       return CH_SPACE;
      1:       return CH_TAB;
      2:       return CH_CR;
      default: return CH_LF;
    endcase
  endfunction

  // Mostly well-formed commands with random content; some noise and some damaged ones.
  task automatic build_command();
    int kind, len, nargs, style, cut;
    logic quoted;
    logic [7:0] c;
    logic [7:0] cmd[$];
    kind = $urandom_range(99);
    if (kind < 12) begin
      repeat ($urandom_range(8, 1)) char_q.push_back(8'($urandom_range(255)));
      return;
    end
    repeat ($urandom_range(2)) cmd.push_back(ws_char());
    len = ($urandom_range(99) < 5) ? $urandom_range(MAX_TOKEN_LEN + 2, MAX_TOKEN_LEN - 1)
                                   : $urandom_range(8, 1);
    repeat (len) begin
      do c = ($urandom_range(99) < 90) ? 8'($urandom_range(8'h7E, 8'h21))
                                       : 8'($urandom_range(255));
      while (c == CH_OPEN);
      cmd.push_back(c);
    end
    cmd.push_back(CH_OPEN);
    nargs = ($urandom_range(99) < 6) ? $urandom_range(MAX_ARGS + 2, MAX_ARGS - 1)
                                     : $urandom_range(4);
    for (int i = 0; i < nargs; i++) begin
      if (i > 0)
        cmd.push_back(CH_COMMA);
      style = $urandom_range(99);
      if (style < 10)
        continue;
      quoted = (style < 35);
      if (quoted)
        cmd.push_back(CH_QUOTE);
      else if (style < 40 && i == 0)
        cmd.push_back(8'h00);
      len = ($urandom_range(99) < 4) ? $urandom_range(MAX_TOKEN_LEN + 2, MAX_TOKEN_LEN - 1)
                                     : $urandom_range(6, quoted ? 0 : 1);
      repeat (len) begin
        do begin
          style = $urandom_range(99);
          c = (style < 80) ? 8'($urandom_range(8'h7E, 8'h20)) :
              (style < 88) ? CH_TAB : 8'($urandom_range(255));
        end while (quoted ? (c == CH_QUOTE)
                          : (c == CH_COMMA || c == CH_CLOSE || c == CH_QUOTE));
        cmd.push_back(c);
      end
      if (quoted)
        cmd.push_back(CH_QUOTE);
    end
    cmd.push_back(CH_CLOSE);
    repeat ($urandom_range(2)) cmd.push_back(ws_char());
    if (kind < 22) begin
      cut = $urandom_range(cmd.size() - 1);
      if ($urandom_range(1))
        cmd = cmd[0:cut];
      else
        cmd[cut] = 8'($urandom_range(255));
    end
    foreach (cmd[k]) char_q.push_back(cmd[k]);
  endtask

  task automatic run_stage(input int n_chars);
    int sent;
    sent = 0;
    while (sent < n_chars) begin
      build_command();
      while (char_q.size() != 0) begin
        send_char(char_q.pop_front(), 1'b0, '0);
        sent++;
      end
    end
  endtask

  initial begin
    rst_n         = 1'b0;
    in_tvalid     = 1'b0;
    in_tdata      = 8'h00;
    in_typed      = 1'b0;
    in_want       = '0;
    send_idle_pct = 28;
    recv_idle_pct = 47;
    tok_phase     = PH_NAME;
    tok_offset    = 0;
    tok_args      = 0;
    tok_first_nz  = 1'b0;

    // name with extreme bytes and a stray ')', then args, quotes, restart, empty call
    add_row(8'h61,    1'b1,
            literal_result(1'b1, 1'b0, 3'd0, 5'd0, 8'h61, 1'b0, 1'b0, 4'd0, PH_NAME));
    add_row(8'h00,    1'b1,
            literal_result(1'b1, 1'b0, 3'd0, 5'd1, 8'h00, 1'b0, 1'b0, 4'd0, PH_NAME));
    add_row(8'hFF,    1'b1,
            literal_result(1'b1, 1'b0, 3'd0, 5'd2, 8'hFF, 1'b0, 1'b0, 4'd0, PH_NAME));
    add_row(CH_CLOSE, 1'b0, '0);
    add_row(CH_OPEN,  1'b1,
            literal_result(1'b1, 1'b0, 3'd0, 5'd4, 8'h00, 1'b0, 1'b0, 4'd0, PH_ARGS));
    add_row(CH_SPACE, 1'b1,
            literal_result(1'b0, 1'b0, 3'd0, 5'd0, 8'h00, 1'b0, 1'b0, 4'd0, PH_ARGS));
    add_row(CH_TAB,   1'b1,
            literal_result(1'b0, 1'b0, 3'd0, 5'd0, 8'h00, 1'b0, 1'b0, 4'd0, PH_ARGS));
    add_row(8'h78,    1'b0, '0);
    add_row(CH_QUOTE, 1'b0, '0);
    add_row(CH_COMMA, 1'b0, '0);
    add_row(CH_CLOSE, 1'b0, '0);
    add_row(CH_QUOTE, 1'b0, '0);
    add_row(CH_COMMA, 1'b0, '0);
    add_row(CH_COMMA, 1'b0, '0);
    add_row(8'hFF,    1'b0, '0);
    add_row(CH_CLOSE, 1'b0, '0);
    add_row(CH_CR,    1'b1,
            literal_result(1'b0, 1'b0, 3'd0, 5'd0, 8'h00, 1'b0, 1'b0, 4'd0, PH_END));
    add_row(CH_LF,    1'b1,
            literal_result(1'b0, 1'b0, 3'd0, 5'd0, 8'h00, 1'b0, 1'b0, 4'd0, PH_END));
    add_row(CH_SPACE, 1'b1,
            literal_result(1'b0, 1'b0, 3'd0, 5'd0, 8'h00, 1'b0, 1'b0, 4'd0, PH_END));
    add_row(CH_TAB,   1'b1,
            literal_result(1'b0, 1'b0, 3'd0, 5'd0, 8'h00, 1'b0, 1'b0, 4'd0, PH_END));
    add_row(CH_OPEN,  1'b1,
            literal_result(1'b1, 1'b0, 3'd0, 5'd0, CH_OPEN, 1'b0, 1'b0, 4'd0, PH_NAME));
    add_row(CH_OPEN,  1'b0, '0);
    add_row(CH_CLOSE, 1'b1,
            literal_result(1'b1, 1'b1, 3'd0, 5'd0, 8'h00, 1'b1, 1'b0, 4'd0, PH_END));
    add_row(8'h71,    1'b0, '0);

    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    foreach (probe_rows[k])
      send_char(probe_rows[k].ch, probe_rows[k].typed, probe_rows[k].want);
    run_stage(650);

    send_idle_pct = 47;
    recv_idle_pct = 28;
    run_stage(670);

    send_idle_pct = 0;
    recv_idle_pct = 0;
    holdoff_requests++;
    run_stage(670);

    @(negedge clk);
    in_tvalid = 1'b0;
    do @(posedge clk); while (pending_results.size() != 0);
    repeat (8) @(posedge clk);

    if (mismatches == 0 && pending_results.size() == 0)
      $display("SCOREBOARD CLEAN");
    else
      $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule
